[rtl/pump_bypass_spray_sequencer_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the pump/bypass spray sequencer checker
// Implication checks, same-cycle and next-cycle, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef PUMP_BYPASS_SPRAY_SEQUENCER_ASSERT_SVH
`define PUMP_BYPASS_SPRAY_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define PBSS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PBSS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pbss_pkg.sv]
// ----------------------------------------------------------------------------
// pbss_pkg
// Shared types and constants of the pump/bypass spray sequencer.
// ----------------------------------------------------------------------------
package pbss_pkg;

  localparam int unsigned SECS_PER_MIN = 60;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 10;
  localparam int unsigned INTV_SECS_W  = 16;  // 1023 min in seconds
  localparam int unsigned TOUT_SECS_W  = 14;  // 255 min in seconds

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPRAY_ENABLE  = 3'd0,
    CFG_INTERVAL_MIN  = 3'd1,
    CFG_DURATION_SEC  = 3'd2,
    CFG_PRIMING_SEC   = 3'd3,
    CFG_BLOWOFF_SEC   = 3'd4,
    CFG_TIMEOUT_MIN   = 3'd5
  } pbss_cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_TICK      = 2'd0,
    MODE_SPRAY_REQ = 2'd1,
    MODE_SPRAY_OFF = 2'd2
  } pbss_mode_e;

  typedef enum logic [1:0] {
    STATUS_DISABLED = 2'd0,
    STATUS_SPRAYING = 2'd1,
    STATUS_ENABLED  = 2'd2
  } pbss_status_e;

  // reset values of the settings
  localparam logic                   RST_ENABLE    = 1'b1;
  localparam logic [INTV_SECS_W-1:0] RST_INTV_SECS = INTV_SECS_W'(15 * SECS_PER_MIN);
  localparam logic [7:0]             RST_DURATION  = 8'd10;
  localparam logic [7:0]             RST_PRIMING   = 8'd10;
  localparam logic [7:0]             RST_BLOWOFF   = 8'd3;
  localparam logic [TOUT_SECS_W-1:0] RST_TOUT_SECS = TOUT_SECS_W'(10 * SECS_PER_MIN);

  // settings, with minute values held already scaled to seconds
  typedef struct packed {
    logic                   spray_enable;
    logic [INTV_SECS_W-1:0] interval_secs;
    logic [7:0]             duration_secs;
    logic [7:0]             priming_secs;
    logic [7:0]             blowoff_secs;
    logic [TOUT_SECS_W-1:0] timeout_secs;
  } pbss_cfg_t;

  typedef struct packed {
    logic pump_running;
    logic bypass_open;
    logic blowoff_active;
    logic pump_healthy;
  } pbss_flags_t;

  typedef struct packed {
    logic started;
    logic stopped;
    logic timed_out;
    logic blowoff_done;
  } pbss_events_t;

endpackage

[rtl/pbss_cfg.sv]
// ----------------------------------------------------------------------------
// pbss_cfg
// Setting registers; minute settings are scaled to seconds on write.
// ----------------------------------------------------------------------------
module pbss_cfg import pbss_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  logic [CFG_IDX_W-1:0]  wr_idx_i,
  input  logic [CFG_DATA_W-1:0] wr_data_i,
  output pbss_cfg_t             cfg_o
);

  pbss_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (pbss_cfg_idx_e'(wr_idx_i))
        CFG_SPRAY_ENABLE: cfg_d.spray_enable  = wr_data_i[0];
        CFG_INTERVAL_MIN: cfg_d.interval_secs =
            INTV_SECS_W'(wr_data_i) * INTV_SECS_W'(SECS_PER_MIN);
        CFG_DURATION_SEC: cfg_d.duration_secs = wr_data_i[7:0];
        CFG_PRIMING_SEC:  cfg_d.priming_secs  = wr_data_i[7:0];
        CFG_BLOWOFF_SEC:  cfg_d.blowoff_secs  = wr_data_i[7:0];
        CFG_TIMEOUT_MIN:  cfg_d.timeout_secs  =
            TOUT_SECS_W'(wr_data_i[7:0]) * TOUT_SECS_W'(SECS_PER_MIN);
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.spray_enable  <= RST_ENABLE;
      cfg_q.interval_secs <= RST_INTV_SECS;
      cfg_q.duration_secs <= RST_DURATION;
      cfg_q.priming_secs  <= RST_PRIMING;
      cfg_q.blowoff_secs  <= RST_BLOWOFF;
      cfg_q.timeout_secs  <= RST_TOUT_SECS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/pbss_step.sv]
// ----------------------------------------------------------------------------
// pbss_step
// Next-state and event logic for one item: tick, spray request or spray off.
// ----------------------------------------------------------------------------
module pbss_step import pbss_pkg::*; #(
  parameter int unsigned PRESSURE_BITS = 12,
  parameter int unsigned TIMER_BITS    = 17
) (
  input  pbss_cfg_t                cfg_i,
  input  pbss_flags_t              flags_i,
  input  logic [TIMER_BITS-1:0]    pump_elapsed_i,
  input  logic [TIMER_BITS-1:0]    spray_elapsed_i,
  input  logic [PRESSURE_BITS-1:0] last_pressure_i,
  input  logic [1:0]               mode_i,
  input  logic [PRESSURE_BITS-1:0] pressure_i,
  input  logic                     mixing_i,
  output pbss_flags_t              flags_o,
  output logic [TIMER_BITS-1:0]    pump_elapsed_o,
  output logic [TIMER_BITS-1:0]    spray_elapsed_o,
  output logic [PRESSURE_BITS-1:0] last_pressure_o,
  output pbss_events_t             events_o,
  output pbss_status_e             status_o
);

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  pbss_flags_t               fl;
  pbss_events_t              ev;
  logic [TIMER_BITS-1:0]     pe, se;
  logic [PRESSURE_BITS-1:0]  lp;

  always_comb begin
    fl = flags_i;
    ev = '0;
    pe = pump_elapsed_i;
    se = spray_elapsed_i;
    lp = last_pressure_i;

    unique case (pbss_mode_e'(mode_i))
      MODE_TICK: begin
        // timers saturate
        pe = (pump_elapsed_i == TIMER_MAX) ? TIMER_MAX : pump_elapsed_i + 1'b1;
        se = (spray_elapsed_i == TIMER_MAX) ? TIMER_MAX : spray_elapsed_i + 1'b1;

        if (fl.blowoff_active && se >= TIMER_BITS'(cfg_i.blowoff_secs)) begin
          fl.bypass_open    = 1'b0;
          fl.blowoff_active = 1'b0;
          ev.blowoff_done   = 1'b1;
        end

        if (flags_i.pump_running) begin
          if (pe >= TIMER_BITS'(cfg_i.timeout_secs)) begin
            fl.pump_running = 1'b0;
            ev.timed_out    = 1'b1;
          end
          // priming check runs even after a timeout; stop check does not
          if (!mixing_i && !fl.bypass_open && fl.pump_running &&
              se >= TIMER_BITS'(cfg_i.duration_secs)) begin
            fl.bypass_open    = 1'b1;
            fl.blowoff_active = 1'b1;
            fl.pump_running   = 1'b0;
            se                = '0;
            lp                = pressure_i;
            ev.stopped        = 1'b1;
          end else if (!mixing_i && fl.bypass_open &&
                       pe >= TIMER_BITS'(cfg_i.priming_secs)) begin
            fl.bypass_open = 1'b0;
            se             = '0;
          end
        end else begin
          if (!fl.blowoff_active) fl.bypass_open = 1'b0;
          if (fl.pump_healthy && cfg_i.spray_enable &&
              se >= TIMER_BITS'(cfg_i.interval_secs)) begin
            fl.pump_healthy = 1'b1;
            fl.pump_running = 1'b1;
            fl.bypass_open  = 1'b1;
            pe              = '0;
            se              = '0;
            ev.started      = 1'b1;
          end
        end
      end
      MODE_SPRAY_REQ: begin
        fl.pump_healthy = 1'b1;
        fl.pump_running = 1'b1;
        fl.bypass_open  = 1'b1;
        pe              = '0;
        se              = '0;
        ev.started      = 1'b1;
      end
      MODE_SPRAY_OFF: begin
        fl.pump_running = 1'b0;
        fl.bypass_open  = 1'b0;
      end
      default: ;  // unused mode: no change
    endcase
  end

  always_comb begin
    if (!cfg_i.spray_enable)                       status_o = STATUS_DISABLED;
    else if (fl.pump_running && !fl.bypass_open)   status_o = STATUS_SPRAYING;
    else                                           status_o = STATUS_ENABLED;
  end

  assign flags_o         = fl;
  assign events_o        = ev;
  assign pump_elapsed_o  = pe;
  assign spray_elapsed_o = se;
  assign last_pressure_o = lp;

endmodule

[rtl/pump_bypass_spray_sequencer.sv]
// ----------------------------------------------------------------------------
// pump_bypass_spray_sequencer
// Pump and bypass-valve sequencer for one spray cycle, item in, result out.
// ----------------------------------------------------------------------------
// Each input item is a one-second tick, a spray request or a spray-off
// command; each one yields exactly one result item holding the pump and
// bypass drives, the spray status, the pressure latched at the last spray
// stop and four event flags. Throughput is one item per clock unless the
// result side stalls. Each item passes the input register, then one pass
// of step logic, then the result register. The input stage keeps
// taking items while a result waits, as long as the result register is
// free or being drained in the same cycle. Settings are written through the
// cfg channel (always ready) and must only change while no item is in
// flight; interval and pump timeout are given in minutes and held as
// seconds internally. Elapsed-second timers saturate at all ones.
// ----------------------------------------------------------------------------
module pump_bypass_spray_sequencer import pbss_pkg::*; #(
  parameter int unsigned PRESSURE_BITS = 12,
  parameter int unsigned TIMER_BITS    = 17
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration write channel
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  // input items
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               mode_i,
  input  logic [PRESSURE_BITS-1:0] pressure_i,
  input  logic                     mixing_i,
  // result items
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     pump_drive_o,
  output logic                     bypass_drive_o,
  output logic [1:0]               spray_status_o,
  output logic [PRESSURE_BITS-1:0] spray_end_pressure_o,
  output logic                     spray_started_o,
  output logic                     spray_stopped_o,
  output logic                     pump_timed_out_o,
  output logic                     blowoff_done_o
);

  // ---- settings ----
  pbss_cfg_t cfg;

  assign cfg_ready_o = 1'b1;

  pbss_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (cfg_valid_i),
    .wr_idx_i (cfg_index_i),
    .wr_data_i(cfg_data_i),
    .cfg_o    (cfg)
  );

  // ---- input register ----
  logic                     in_valid_q;
  logic [1:0]               mode_q;
  logic [PRESSURE_BITS-1:0] pressure_q;
  logic                     mixing_q;
  logic                     step_fire;   // item moves from input to result reg
  logic                     out_valid_q;

  assign step_fire  = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mode_q     <= mode_i;
      pressure_q <= pressure_i;
      mixing_q   <= mixing_i;
    end
  end

  // ---- sequencer state ----
  pbss_flags_t               flags_q, flags_d;
  logic [TIMER_BITS-1:0]     pump_elapsed_q, pump_elapsed_d;
  logic [TIMER_BITS-1:0]     spray_elapsed_q, spray_elapsed_d;
  logic [PRESSURE_BITS-1:0]  last_pressure_q, last_pressure_d;
  pbss_events_t              events;
  pbss_status_e              status;

  pbss_step #(
    .PRESSURE_BITS(PRESSURE_BITS),
    .TIMER_BITS   (TIMER_BITS)
  ) u_step (
    .cfg_i          (cfg),
    .flags_i        (flags_q),
    .pump_elapsed_i (pump_elapsed_q),
    .spray_elapsed_i(spray_elapsed_q),
    .last_pressure_i(last_pressure_q),
    .mode_i         (mode_q),
    .pressure_i     (pressure_q),
    .mixing_i       (mixing_q),
    .flags_o        (flags_d),
    .pump_elapsed_o (pump_elapsed_d),
    .spray_elapsed_o(spray_elapsed_d),
    .last_pressure_o(last_pressure_d),
    .events_o       (events),
    .status_o       (status)
  );

  // state commits only when the item actually advances
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q.pump_running   <= 1'b0;
      flags_q.bypass_open    <= 1'b0;
      flags_q.blowoff_active <= 1'b0;
      flags_q.pump_healthy   <= 1'b1;
      pump_elapsed_q         <= '0;
      spray_elapsed_q        <= '0;
      last_pressure_q        <= '0;
    end else if (step_fire) begin
      flags_q         <= flags_d;
      pump_elapsed_q  <= pump_elapsed_d;
      spray_elapsed_q <= spray_elapsed_d;
      last_pressure_q <= last_pressure_d;
    end
  end

  // ---- result register ----
  pbss_flags_t              res_flags_q;
  pbss_events_t             res_events_q;
  pbss_status_e             res_status_q;
  logic [PRESSURE_BITS-1:0] res_pressure_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      res_flags_q    <= flags_d;
      res_events_q   <= events;
      res_status_q   <= status;
      res_pressure_q <= last_pressure_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign pump_drive_o         = res_flags_q.pump_running;
  assign bypass_drive_o       = res_flags_q.bypass_open;
  assign spray_status_o       = res_status_q;
  assign spray_end_pressure_o = res_pressure_q;
  assign spray_started_o      = res_events_q.started;
  assign spray_stopped_o      = res_events_q.stopped;
  assign pump_timed_out_o     = res_events_q.timed_out;
  assign blowoff_done_o       = res_events_q.blowoff_done;

endmodule

[rtl/pbss_checker.sv]
// ----------------------------------------------------------------------------
// pbss_checker
// Port-level checks of the spray sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "pump_bypass_spray_sequencer_assert.svh"

module pbss_checker import pbss_pkg::*; #(
  parameter int unsigned PRESSURE_BITS = 12
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic                     pump_drive_o,
  input logic                     bypass_drive_o,
  input logic [1:0]               spray_status_o,
  input logic [PRESSURE_BITS-1:0] spray_end_pressure_o,
  input logic                     spray_started_o,
  input logic                     spray_stopped_o,
  input logic                     pump_timed_out_o
);

  // stalled result holds
  `PBSS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(spray_end_pressure_o) && $stable(pump_drive_o), "stalled result changed")
  // a started spray primes with pump and bypass on
  `PBSS_ASSERT_IMP(a_start_drv, clk_i, rst_ni, out_valid_o && spray_started_o, pump_drive_o && bypass_drive_o, "spray start without pump and bypass")
  // a spray stop opens the bypass for blow-off with the pump off
  `PBSS_ASSERT_IMP(a_stop_drv, clk_i, rst_ni, out_valid_o && spray_stopped_o, !pump_drive_o && bypass_drive_o && !spray_started_o, "spray stop drive mismatch")
  // timeout leaves the pump off; spraying status needs pump on, bypass shut
  `PBSS_ASSERT_IMP(a_tout_drv, clk_i, rst_ni, out_valid_o && (pump_timed_out_o || spray_status_o == STATUS_SPRAYING), (pump_timed_out_o && !pump_drive_o) || (!pump_timed_out_o && pump_drive_o && !bypass_drive_o), "timeout or spraying status mismatch")

endmodule

bind pump_bypass_spray_sequencer pbss_checker #(
  .PRESSURE_BITS(PRESSURE_BITS)
) u_pbss_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_o         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .pump_drive_o        (pump_drive_o),
  .bypass_drive_o      (bypass_drive_o),
  .spray_status_o      (spray_status_o),
  .spray_end_pressure_o(spray_end_pressure_o),
  .spray_started_o     (spray_started_o),
  .spray_stopped_o     (spray_stopped_o),
  .pump_timed_out_o    (pump_timed_out_o)
);

[tb/pump_bypass_spray_sequencer_tb.sv]
// ----------------------------------------------------------------------------
// pump_bypass_spray_sequencer_tb
// Self-checking bench for the pump/bypass spray sequencer.
// ----------------------------------------------------------------------------
// Items go in through a valid/ready port with random gaps, and results leave
// through a valid/ready port with random stalls. A cycle model of the
// sequencer runs alongside. It keeps its own settings, flags and timers, and
// queues the expected result of every accepted item. Each result is checked
// field by field against the oldest entry in that queue. Settings change
// only while nothing is in flight. Named tests cover reset state, a manual
// spray cycle, zero settings, disabled spraying with maximum settings, random
// spray phases, output back-pressure, a drained pause and an interval restart.
// ----------------------------------------------------------------------------
module pump_bypass_spray_sequencer_tb import pbss_pkg::*;;

  localparam int unsigned PRESS_W     = 12;
  localparam int unsigned TMR_W       = 17;
  localparam int unsigned HOLD_CYCLES = 150;   // long receiver stall
  localparam int unsigned STALL_LIMIT = 2000;  // cycles without any handshake
  localparam int unsigned MAX_REPORTS = 50;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;  // no effect on the sequencer

  typedef struct packed {
    logic               pump;
    logic               bypass;
    pbss_status_e       status;
    logic [PRESS_W-1:0] end_pressure;
    logic               started;
    logic               stopped;
    logic               timed_out;
    logic               blowoff_done;
  } spray_result_t;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_valid_i  = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i   = '0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_ready_o;
  logic [1:0]            mode_i       = '0;
  logic [PRESS_W-1:0]    pressure_i   = '0;
  logic                  mixing_i     = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i  = 1'b0;
  logic                  pump_drive_o;
  logic                  bypass_drive_o;
  logic [1:0]            spray_status_o;
  logic [PRESS_W-1:0]    spray_end_pressure_o;
  logic                  spray_started_o;
  logic                  spray_stopped_o;
  logic                  pump_timed_out_o;
  logic                  blowoff_done_o;

  // model settings, reset values
  logic       set_enable       = 1'b1;
  logic [9:0] set_interval_min = 10'd15;
  logic [7:0] set_duration     = 8'd10;
  logic [7:0] set_priming      = 8'd10;
  logic [7:0] set_blowoff      = 8'd3;
  logic [7:0] set_timeout_min  = 8'd10;

  // model state, reset values
  logic               pump_on      = 1'b0;
  logic               bypass_on    = 1'b0;
  logic               blowoff_on   = 1'b0;
  logic               pump_ok      = 1'b1;
  logic [TMR_W-1:0]   pump_secs    = '0;
  logic [TMR_W-1:0]   spray_secs   = '0;
  logic [PRESS_W-1:0] end_pressure = '0;

  spray_result_t pending_results[$];

  int unsigned error_count  = 0;
  int unsigned tx_idle_pct  = 30;
  int unsigned rx_idle_pct  = 30;
  int unsigned rx_hold_req  = 0;
  int unsigned rx_hold_seen = 0;
  int unsigned rx_hold_left = 0;
  int unsigned stall_cycles = 0;

  pump_bypass_spray_sequencer #(
    .PRESSURE_BITS(PRESS_W),
    .TIMER_BITS   (TMR_W)
  ) u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .mode_i              (mode_i),
    .pressure_i          (pressure_i),
    .mixing_i            (mixing_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .pump_drive_o        (pump_drive_o),
    .bypass_drive_o      (bypass_drive_o),
    .spray_status_o      (spray_status_o),
    .spray_end_pressure_o(spray_end_pressure_o),
    .spray_started_o     (spray_started_o),
    .spray_stopped_o     (spray_stopped_o),
    .pump_timed_out_o    (pump_timed_out_o),
    .blowoff_done_o      (blowoff_done_o)
  );

  always #6 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Sequencer model
  // --------------------------------------------------------------------------
  function automatic logic [TMR_W-1:0] sat_inc(logic [TMR_W-1:0] t);
    return (t == '1) ? t : t + 1'b1;
  endfunction

  function automatic void begin_spray();
    pump_ok    = 1'b1;
    pump_on    = 1'b1;
    bypass_on  = 1'b1;
    pump_secs  = '0;
    spray_secs = '0;
  endfunction

  // Applies one item to the model and returns the result it produces.
  function automatic spray_result_t advance_sequencer(logic [1:0] mode,
                                                      logic [PRESS_W-1:0] press,
                                                      logic mix);
    spray_result_t r;
    r = '0;
    case (mode)
      MODE_TICK: begin
        pump_secs  = sat_inc(pump_secs);
        spray_secs = sat_inc(spray_secs);
        if (blowoff_on && spray_secs >= set_blowoff) begin
          bypass_on      = 1'b0;
          blowoff_on     = 1'b0;
          r.blowoff_done = 1'b1;
        end
        if (pump_on) begin
          if (pump_secs >= set_timeout_min * SECS_PER_MIN) begin
            pump_on     = 1'b0;
            r.timed_out = 1'b1;
          end
          // priming check still runs after a timeout, the stop check does not
          if (!mix && !bypass_on && pump_on && spray_secs >= set_duration) begin
            bypass_on    = 1'b1;
            blowoff_on   = 1'b1;
            pump_on      = 1'b0;
            spray_secs   = '0;
            end_pressure = press;
            r.stopped    = 1'b1;
          end else if (!mix && bypass_on && pump_secs >= set_priming) begin
            bypass_on  = 1'b0;
            spray_secs = '0;
          end
        end else begin
          if (!blowoff_on) bypass_on = 1'b0;
          if (pump_ok && set_enable &&
              spray_secs >= set_interval_min * SECS_PER_MIN) begin
            begin_spray();
            r.started = 1'b1;
          end
        end
      end
      MODE_SPRAY_REQ: begin
        begin_spray();
        r.started = 1'b1;
      end
      MODE_SPRAY_OFF: begin
        pump_on   = 1'b0;
        bypass_on = 1'b0;
      end
      default: ;
    endcase
    if (!set_enable) r.status = STATUS_DISABLED;
    else if (pump_on && !bypass_on) r.status = STATUS_SPRAYING;
    else r.status = STATUS_ENABLED;
    r.pump         = pump_on;
    r.bypass       = bypass_on;
    r.end_pressure = end_pressure;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off on request
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rx_hold_seen != rx_hold_req) begin
      rx_hold_seen <= rx_hold_req;
      rx_hold_left <= HOLD_CYCLES;
      out_ready_i  <= 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_ready_i  <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, int unsigned want,
                                      int unsigned got);
    if (want != got) begin
      if (error_count < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d",
                 $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin : check_result
    spray_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        if (error_count < MAX_REPORTS)
          $display("%0t: result item with none expected", $time);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("pump_drive", want.pump, pump_drive_o);
        check_field("bypass_drive", want.bypass, bypass_drive_o);
        check_field("spray_status", want.status, spray_status_o);
        check_field("spray_end_pressure", want.end_pressure, spray_end_pressure_o);
        check_field("spray_started", want.started, spray_started_o);
        check_field("spray_stopped", want.stopped, spray_stopped_o);
        check_field("pump_timed_out", want.timed_out, pump_timed_out_o);
        check_field("blowoff_done", want.blowoff_done, blowoff_done_o);
      end
    end
  end

  // Watchdog: ends the run when no handshake happens for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("pump_bypass_spray_sequencer test failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  // Offers one item and books its expected result once it is taken. Valid
  // stays high after acceptance so items can follow back to back; a random
  // gap or wait_drained lowers it.
  task automatic send_item(input logic [1:0] mode, input logic [PRESS_W-1:0] press,
                           input logic mix);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    pressure_i <= press;
    mixing_i   <= mix;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(advance_sequencer(mode, press, mix));
  endtask

  task automatic send_random_item();
    int unsigned pick;
    logic [1:0]  mode;
    pick = $urandom_range(99);
    if (pick < 84)      mode = MODE_TICK;
    else if (pick < 92) mode = MODE_SPRAY_REQ;
    else if (pick < 97) mode = MODE_SPRAY_OFF;
    else                mode = MODE_UNUSED;
    send_item(mode, PRESS_W'($urandom()), $urandom_range(99) < 25);
  endtask

  // Stops offering items and waits until every booked result has arrived.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_setting(input pbss_cfg_idx_e idx,
                               input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_SPRAY_ENABLE: set_enable       = val[0];
      CFG_INTERVAL_MIN: set_interval_min = val[9:0];
      CFG_DURATION_SEC: set_duration     = val[7:0];
      CFG_PRIMING_SEC:  set_priming      = val[7:0];
      CFG_BLOWOFF_SEC:  set_blowoff      = val[7:0];
      CFG_TIMEOUT_MIN:  set_timeout_min  = val[7:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic en, input logic [9:0] intv,
                                input logic [7:0] dur, input logic [7:0] prime,
                                input logic [7:0] blow, input logic [7:0] tout);
    wait_drained();
    write_setting(CFG_SPRAY_ENABLE, CFG_DATA_W'(en));
    write_setting(CFG_INTERVAL_MIN, CFG_DATA_W'(intv));
    write_setting(CFG_DURATION_SEC, CFG_DATA_W'(dur));
    write_setting(CFG_PRIMING_SEC, CFG_DATA_W'(prime));
    write_setting(CFG_BLOWOFF_SEC, CFG_DATA_W'(blow));
    write_setting(CFG_TIMEOUT_MIN, CFG_DATA_W'(tout));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset settings: idle tick, unused mode, spray off with nothing running.
  task automatic test_reset_state();
    send_item(MODE_TICK, '0, 1'b0);
    send_item(MODE_UNUSED, '1, 1'b1);
    send_item(MODE_SPRAY_OFF, '0, 1'b0);
  endtask

  // Manual start, priming, mixing hold, stop with pressure capture, spray off
  // during blow-off (blow-off flag and timers kept), restart at interval zero.
  task automatic test_manual_cycle();
    apply_settings(1'b1, 10'd0, 8'd1, 8'd1, 8'd2, 8'd1);
    send_item(MODE_SPRAY_REQ, '0, 1'b0);
    send_item(MODE_TICK, '0, 1'b0);
    send_item(MODE_TICK, 12'h555, 1'b1);
    send_item(MODE_TICK, '1, 1'b0);
    send_item(MODE_SPRAY_OFF, 12'haaa, 1'b0);
    send_item(MODE_TICK, '0, 1'b0);
    send_item(MODE_TICK, '0, 1'b1);
    send_item(MODE_TICK, '0, 1'b0);
  endtask

  // Every time setting zero: timeout fires on the first tick and priming
  // still closes the bypass on that same tick.
  task automatic test_zero_settings();
    apply_settings(1'b1, 10'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_item(MODE_SPRAY_REQ, 12'h0f0, 1'b0);
    send_item(MODE_TICK, 12'h00f, 1'b0);
    send_item(MODE_TICK, 12'hf00, 1'b0);
    send_item(MODE_TICK, '1, 1'b1);
    send_item(MODE_TICK, '0, 1'b0);
  endtask

  // Disabled spraying with every other setting at its maximum; a manual
  // request still starts the pump.
  task automatic test_disabled_request();
    apply_settings(1'b0, 10'd1023, 8'd255, 8'd255, 8'd255, 8'd255);
    send_item(MODE_TICK, '0, 1'b0);
    send_item(MODE_SPRAY_REQ, '1, 1'b0);
    send_item(MODE_TICK, '0, 1'b0);
    send_item(MODE_TICK, '1, 1'b1);
    send_item(MODE_SPRAY_OFF, '0, 1'b1);
    send_item(MODE_UNUSED, '1, 1'b0);
  endtask

  // Random phases, mostly short timings so full spray cycles come around
  // often; the first two phases sit at the setting extremes.
  task automatic test_random_phases();
    logic [7:0] dur_hi;
    for (int p = 0; p < 8; p++) begin
      if (p == 0) begin
        apply_settings(1'b1, 10'd1023, 8'd255, 8'd255, 8'd255, 8'd255);
      end else if (p == 1) begin
        apply_settings(1'b0, 10'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      end else begin
        dur_hi = ($urandom_range(3) == 0) ? 8'd90 : 8'd15;
        apply_settings($urandom_range(99) < 80, 10'($urandom_range(2)),
                       8'($urandom_range(dur_hi)), 8'($urandom_range(15)),
                       8'($urandom_range(8)), 8'($urandom_range(2)));
      end
      // one phase runs with no idling on either side
      tx_idle_pct = (p == 4) ? 0 : 30;
      rx_idle_pct = (p == 4) ? 0 : 30;
      repeat (190) send_random_item();
    end
    tx_idle_pct = 30;
    rx_idle_pct = 30;
  endtask

  // Receiver holds off while items keep coming, so the block stalls input.
  task automatic test_output_backpressure();
    apply_settings(1'b1, 10'd0, 8'd5, 8'd3, 8'd2, 8'd1);
    rx_hold_req <= rx_hold_req + 1;
    tx_idle_pct = 0;
    repeat (60) send_random_item();
    tx_idle_pct = 30;
  endtask

  // Sender pauses until every result is back, then carries on.
  task automatic test_drained_pause();
    repeat (20) send_random_item();
    wait_drained();
    repeat (20) send_random_item();
  endtask

  // A manual spray runs its whole cycle; one minute of ticks after the stop
  // the interval brings the next spray on its own.
  task automatic test_interval_restart();
    apply_settings(1'b1, 10'd1, 8'd5, 8'd3, 8'd2, 8'd2);
    send_item(MODE_SPRAY_REQ, '0, 1'b0);
    repeat (75) send_item(MODE_TICK, PRESS_W'($urandom()), 1'b0);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_manual_cycle();
    test_zero_settings();
    test_disabled_request();
    test_random_phases();
    test_output_backpressure();
    test_drained_pause();
    test_interval_restart();

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("pump_bypass_spray_sequencer test passed");
    end else begin
      $display("pump_bypass_spray_sequencer test failed");
    end
    $finish;
  end

endmodule
